### sv/sha256_hex_hash_chain_unit_assert.svh
// Assertion macros shared by the hash chain modules.
`ifndef SHA256_HEX_HASH_CHAIN_UNIT_ASSERT_SVH
`define SHA256_HEX_HASH_CHAIN_UNIT_ASSERT_SVH
// Same-cycle implication, checked at every clock edge outside reset.
`define SHCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash chain assertion failed");
// Next-cycle implication.
`define SHCU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash chain assertion failed");
`endif

### sv/shcu_pkg.sv
// Package with the shared types and constants of the hash chain unit.
package shcu_pkg;
	localparam int LEN_W = 7;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_HASH   = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_SEED_LONG  = 2'd1;
	localparam logic [1:0] ST_CHAIN_FULL = 2'd2;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic       seed_wr;
		logic       hash_start;
		logic       rd_en;
		logic [7:0] rd_pos;
		logic       ld_shift;
		logic       blk_start;
		logic       round_en;
		logic [5:0] round_idx;
		logic       add_h;
		logic       out_load;
		logic [1:0] out_status;
		logic       hex_wr;
		logic [5:0] hex_idx;
	} shcu_cmd_t;

	typedef struct packed {
		logic       overflow;
		logic       chain_full;
		logic [1:0] nblk;
	} shcu_sts_t;
endpackage

### sv/shcu_dp.sv
// Datapath: message memory, padding, SHA-256 rounds, hex writeback and result registers.
`include "sha256_hex_hash_chain_unit_assert.svh"
module shcu_dp import shcu_pkg::*; #(
	parameter int MAX_HASHES = 255,
	parameter int SEED_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  shcu_cmd_t   cmd,
	input  logic [7:0]  seed_byte,
	output shcu_sts_t   sts,
	output logic [63:0] hash_word0,
	output logic [63:0] hash_word1,
	output logic [63:0] hash_word2,
	output logic [63:0] hash_word3,
	output logic [7:0]  hash_index,
	output logic [1:0]  status
);
	localparam int AW = $clog2(SEED_BYTES);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'h0, n};
		end
		return 8'h37 + {4'h0, n};
	endfunction

	logic [7:0]       mem_q [SEED_BYTES];
	logic [LEN_W-1:0] len_q;
	logic [7:0]       chain_q;
	logic             ovf_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       pos_s1;
	logic [511:0]     win_q;
	logic [31:0]      h_q [8];
	logic [31:0]      v_q [8];
	logic [63:0]      w0_q, w1_q, w2_q, w3_q;
	logic [7:0]       idx_q;
	logic [1:0]       stat_q;

	logic [LEN_W-1:0] base_len;
	logic             seed_full;
	logic [1:0]       nblk;
	logic [7:0]       pad_byte;
	logic [255:0]     hv, hv_sh;
	logic [3:0]       nib;
	logic [31:0]      wa, wb, wc, wd, s0, s1, wn, t1, t2, ch, mj;

	assign base_len  = (chain_q != 8'd0) ? '0 : len_q;
	assign seed_full = base_len == LEN_W'(SEED_BYTES);
	assign nblk = (len_q <= 7'd55) ? 2'd1 : ((len_q <= 7'd119) ? 2'd2 : 2'd3);
	assign hv = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
	assign hv_sh = hv << {cmd.hex_idx, 2'b00};
	assign nib = hv_sh[255:252];

	assign sts.overflow   = ovf_q;
	assign sts.chain_full = chain_q == 8'(MAX_HASHES);
	assign sts.nblk       = nblk;

	always_ff @(posedge clk) begin
		if (cmd.seed_wr && !seed_full) begin
			mem_q[AW'(base_len)] <= seed_byte;
		end else if (cmd.hex_wr) begin
			mem_q[AW'(cmd.hex_idx)] <= hex_char(nib);
		end
		if (cmd.rd_en && (cmd.rd_pos < {1'b0, len_q})) begin
			rd_data_q <= mem_q[AW'(cmd.rd_pos)];
		end
		pos_s1 <= cmd.rd_pos;
	end

	always_comb begin
		if (pos_s1 < {1'b0, len_q}) begin
			pad_byte = rd_data_q;
		end else if (pos_s1 == {1'b0, len_q}) begin
			pad_byte = 8'h80;
		end else if (pos_s1[7:6] == nblk - 2'd1 && pos_s1[5:0] == 6'd63) begin
			pad_byte = {len_q[4:0], 3'b000};
		end else if (pos_s1[7:6] == nblk - 2'd1 && pos_s1[5:0] == 6'd62) begin
			pad_byte = {6'b0, len_q[6:5]};
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign wa = win_q[511:480];
	assign wb = win_q[479:448];
	assign wc = win_q[223:192];
	assign wd = win_q[63:32];
	assign s0 = rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3);
	assign s1 = rotr(wd, 17) ^ rotr(wd, 19) ^ (wd >> 10);
	assign wn = wa + s0 + wc + s1;
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) + ch
		+ ROUND_K[cmd.round_idx] + wa;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) + mj;

	always_ff @(posedge clk) begin
		if (cmd.ld_shift) begin
			win_q <= {win_q[503:0], pad_byte};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], wn};
		end
		for (int i = 0; i < 8; i++) begin
			if (cmd.hash_start) begin
				h_q[i] <= INIT_H[i];
			end else if (cmd.add_h) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
		if (cmd.blk_start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round_en) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
		if (cmd.out_load) begin
			stat_q <= cmd.out_status;
			if (cmd.out_status == ST_OK) begin
				w0_q  <= hv[255:192];
				w1_q  <= hv[191:128];
				w2_q  <= hv[127:64];
				w3_q  <= hv[63:0];
				idx_q <= chain_q + 8'd1;
			end else begin
				w0_q  <= '0;
				w1_q  <= '0;
				w2_q  <= '0;
				w3_q  <= '0;
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			chain_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.seed_wr) begin
			chain_q <= '0;
			ovf_q   <= ((chain_q != 8'd0) ? 1'b0 : ovf_q) | seed_full;
			len_q   <= seed_full ? base_len : base_len + 7'd1;
		end else if (cmd.out_load) begin
			if (cmd.out_status == ST_SEED_LONG) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.out_status == ST_OK) begin
				chain_q <= chain_q + 8'd1;
				len_q   <= 7'd64;
			end
		end
	end

	assign hash_word0 = w0_q;
	assign hash_word1 = w1_q;
	assign hash_word2 = w2_q;
	assign hash_word3 = w3_q;
	assign hash_index = idx_q;
	assign status     = stat_q;

	`SHCU_ASSERT_IMP(a_len_range, 1'b1, len_q <= LEN_W'(SEED_BYTES))
endmodule

### sv/shcu_ctrl.sv
// Controller state machine that sequences loading, rounds, result and hex writeback.
`include "sha256_hex_hash_chain_unit_assert.svh"
module shcu_ctrl import shcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      operation,
	input  logic [7:0] seed_byte,
	output logic      out_valid,
	input  logic      out_ready,
	output shcu_cmd_t cmd,
	input  shcu_sts_t sts
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_ROUND  = 3'd2;
	localparam logic [2:0] S_ADDH   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;
	localparam logic [2:0] S_HEX    = 3'd5;

	logic [2:0] state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic [1:0] blk_q, blk_d;
	logic [1:0] res_q, res_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		blk_d   = blk_q;
		res_d   = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_APPEND) begin
						cmd.seed_wr = seed_byte != 8'd0;
					end else if (sts.overflow) begin
						res_d   = ST_SEED_LONG;
						state_d = S_RESULT;
					end else if (sts.chain_full) begin
						res_d   = ST_CHAIN_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.hash_start = 1'b1;
						res_d   = ST_OK;
						cnt_d   = '0;
						blk_d   = '0;
						state_d = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				cmd.rd_en    = !cnt_q[6];
				cmd.rd_pos   = {blk_q, cnt_q[5:0]};
				cmd.ld_shift = cnt_q != 7'd0;
				if (cnt_q[6]) begin
					cmd.blk_start = 1'b1;
					cnt_d   = '0;
					state_d = S_ROUND;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_ROUND: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = cnt_q[5:0];
				if (cnt_q[5:0] == 6'd63) begin
					state_d = S_ADDH;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			S_ADDH: begin
				cmd.add_h = 1'b1;
				if (blk_q + 2'd1 == sts.nblk) begin
					state_d = S_RESULT;
				end else begin
					blk_d   = blk_q + 2'd1;
					cnt_d   = '0;
					state_d = S_LOAD;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = res_q;
					cnt_d   = '0;
					state_d = (res_q == ST_OK) ? S_HEX : S_IDLE;
				end
			end
			S_HEX: begin
				cmd.hex_wr  = 1'b1;
				cmd.hex_idx = cnt_q[5:0];
				if (cnt_q[5:0] == 6'd63) begin
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 7'd1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			blk_q       <= '0;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			blk_q   <= blk_d;
			res_q   <= res_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SHCU_ASSERT_IMP(a_load_slot, cmd.out_load, !out_valid_q || out_ready)
	`SHCU_ASSERT_NEXT(a_req_busy, in_valid && in_ready && operation == OP_HASH, !in_ready)
	`SHCU_ASSERT_IMP(a_blk_range, state_q == S_LOAD, blk_q < sts.nblk)
endmodule

### sv/sha256_hex_hash_chain_unit.sv
// Top level of the SHA-256 hex hash chain unit.
// Input channel: in_valid/in_ready with operation and seed_byte. An append beat
// (operation 0) stores one seed byte; a zero byte is ignored. A hash beat
// (operation 1) yields one result beat on out_valid/out_ready with
// hash_word0..3, hash_index and status.
// A hash request loads each 64-byte padded block, then runs 64 rounds, one per
// cycle, and an add step, for one to three blocks by message length (two for
// every chained hash). Then the result is registered and the digest is written
// back as hex text, one character per cycle, 64 characters in all.
// Append beats are taken while a result waits; a stalled result holds the next
// hash request in the result step until the receiver takes it.
// Reset clears the seed length, chain position, overflow flag and output valid;
// the message memory is not cleared and holds no valid data until written.
module sha256_hex_hash_chain_unit import shcu_pkg::*; #(
	parameter int MAX_HASHES = 255,
	parameter int SEED_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  seed_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_word0,
	output logic [63:0] hash_word1,
	output logic [63:0] hash_word2,
	output logic [63:0] hash_word3,
	output logic [7:0]  hash_index,
	output logic [1:0]  status
);
	shcu_cmd_t cmd;
	shcu_sts_t sts;

	shcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.seed_byte (seed_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	shcu_dp #(
		.MAX_HASHES (MAX_HASHES),
		.SEED_BYTES (SEED_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_byte  (seed_byte),
		.sts        (sts),
		.hash_word0 (hash_word0),
		.hash_word1 (hash_word1),
		.hash_word2 (hash_word2),
		.hash_word3 (hash_word3),
		.hash_index (hash_index),
		.status     (status)
	);
endmodule
